>>> src/mroe_pkg.sv
// Shared constants, types and helpers for the matrix row operation engine.
// No dependencies; used by every module under src.
package mroe_pkg;

    localparam int ROWS_DEF = 4;
    localparam int COLS_DEF = 8;
    localparam int DATA_W   = 32;
    localparam int IN_TDATA_W = 40;   // dest_row, src_row, col, operand, pad
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;

    // divider: numerator |d|*2^17 + |f|, denominator |f|*2
    localparam int DIV_NW   = 49;
    localparam int DIV_DW   = 33;
    localparam int DIV_RW   = DIV_DW + 1;
    localparam int DIV_CW   = $clog2(DIV_NW);
    localparam int MAG_W    = 50;

    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DIV   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SWAP  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIVZ = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Apply sign to a magnitude and clamp to Q16.16; msb of result is the flag.
    function automatic logic [DATA_W:0] sat_q(input logic neg, input logic [MAG_W-1:0] mag);
        logic [DATA_W-1:0] v;
        logic              f;
        if (!neg && mag > MAG_W'(32'h7fffffff)) begin
            f = 1'b1;
            v = 32'h7fffffff;
        end else if (neg && mag > MAG_W'(32'h80000000)) begin
            f = 1'b1;
            v = 32'h80000000;
        end else begin
            f = 1'b0;
            v = neg ? (~mag[DATA_W-1:0] + 32'd1) : mag[DATA_W-1:0];
        end
        return {f, v};
    endfunction

endpackage

>>> src/matrix_row_operation_engine_core.sv
// Matrix row operation engine: top level, command sequencer and datapath.
// Depends on mroe_pkg, mroe_mem and mroe_div.
// Row commands walk every column of the row in turn; write and read touch
// one element, and divide waits on the 49-step divider for each element.
// One command at a time.
// Reset clears the sequencer and output valid; matrix contents are undefined.
module matrix_row_operation_engine_core #(
    parameter int ROWS = mroe_pkg::ROWS_DEF,
    parameter int COLS = mroe_pkg::COLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // dest_row[1:0], src_row[3:2], col[6:4], operand[38:7], zero pad[39]
    input  logic [mroe_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // cmd[2:0]
    input  logic [mroe_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_value[31:0]
    output logic [mroe_pkg::DATA_W-1:0]     m_axis_tdata,
    // status[1:0]
    output logic [mroe_pkg::STAT_W-1:0]     m_axis_tuser
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLS);
    localparam int DW    = mroe_pkg::DATA_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ISSUE = 9'b000000010,
        S_LOAD  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_SUM   = 9'b000010000,
        S_RND   = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_SWP   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [mroe_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [1:0]                   dr_reg, dr_next;
    logic [1:0]                   sr_reg, sr_next;
    logic [2:0]                   col_reg, col_next;
    logic [DW-1:0]                op_reg, op_next;
    logic [CW-1:0]                i_reg, i_next;
    logic [DW-1:0]                d_reg, d_next;
    logic [DW-1:0]                s_reg, s_next;
    logic signed [63:0]           prod_reg, prod_next;
    logic signed [65:0]           wide_reg, wide_next;
    logic                         sat_reg, sat_next;
    logic [mroe_pkg::STAT_W-1:0]  stat_reg, stat_next;
    logic [DW-1:0]                rd_reg, rd_next;
    logic                         ovalid_reg, ovalid_next;
    logic [DW-1:0]                odata_reg, odata_next;
    logic [mroe_pkg::STAT_W-1:0]  ouser_reg, ouser_next;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr, addr_a, addr_b;
    logic [DW-1:0]                mem_wdata, rdata_a, rdata_b;

    logic                         div_start;
    logic [mroe_pkg::DIV_NW-1:0]  div_num, div_quo;
    logic [mroe_pkg::DIV_DW-1:0]  div_den;
    mroe_pkg::div_stat_t          div_stat;

    logic                         in_acc;
    logic [1:0]                   in_dr, in_sr;
    logic [2:0]                   in_col;
    logic [DW-1:0]                in_op;
    logic                         dr_ok, sr_ok, col_ok;
    logic [DW-1:0]                abs_d, abs_f;
    logic [65:0]                  wmag;
    logic [mroe_pkg::MAG_W-1:0]   rmag;
    logic [DW:0]                  satv;
    logic                         last_col;

    mroe_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    mroe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_dr         = s_axis_tdata[1:0];
    assign in_sr         = s_axis_tdata[3:2];
    assign in_col        = s_axis_tdata[6:4];
    assign in_op         = s_axis_tdata[38:7];
    assign dr_ok         = int'(in_dr) < ROWS;
    assign sr_ok         = int'(in_sr) < ROWS;
    assign col_ok        = int'(in_col) < COLS;

    assign addr_a = AW'(int'(dr_reg) * COLS +
                        ((cmd_reg == mroe_pkg::CMD_READ) ? int'(col_reg) : int'(i_reg)));
    assign addr_b = AW'(int'(sr_reg) * COLS + int'(i_reg));

    // divider operands straight from the read data and the operand register
    assign abs_d   = rdata_a[DW-1] ? (~rdata_a + 32'd1) : rdata_a;
    assign abs_f   = op_reg[DW-1] ? (~op_reg + 32'd1) : op_reg;
    assign div_num = {abs_d, 17'd0} + mroe_pkg::DIV_NW'(abs_f);
    assign div_den = {abs_f, 1'b0};

    // round to nearest, ties away from zero, on the magnitude
    assign wmag = wide_reg[65] ? 66'(-wide_reg) : 66'(wide_reg);
    assign rmag = mroe_pkg::MAG_W'((wmag + 66'h8000) >> 16);

    assign last_col = (i_reg == CW'(COLS - 1));

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        dr_next     = dr_reg;
        sr_next     = sr_reg;
        col_next    = col_reg;
        op_next     = op_reg;
        i_next      = i_reg;
        d_next      = d_reg;
        s_next      = s_reg;
        prod_next   = prod_reg;
        wide_next   = wide_reg;
        sat_next    = sat_reg;
        stat_next   = stat_reg;
        rd_next     = rd_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        mem_we      = 1'b0;
        mem_waddr   = addr_a;
        mem_wdata   = s_reg;
        div_start   = 1'b0;
        satv        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next   = s_axis_tuser;
                    dr_next    = in_dr;
                    sr_next    = in_sr;
                    col_next   = in_col;
                    op_next    = in_op;
                    i_next     = '0;
                    sat_next   = 1'b0;
                    stat_next  = mroe_pkg::ST_OK;
                    rd_next    = '0;
                    state_next = S_DONE;
                    case (s_axis_tuser)
                        mroe_pkg::CMD_WRITE:
                        begin
                            if (dr_ok && col_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(int'(in_dr) * COLS + int'(in_col));
                                mem_wdata = in_op;
                            end
                        end
                        mroe_pkg::CMD_READ:
                        begin
                            if (dr_ok && col_ok)
                            begin
                                state_next = S_ISSUE;
                            end
                        end
                        mroe_pkg::CMD_ADD, mroe_pkg::CMD_SUB, mroe_pkg::CMD_SWAP:
                        begin
                            if (dr_ok && sr_ok)
                            begin
                                state_next = S_ISSUE;
                            end
                        end
                        mroe_pkg::CMD_MUL:
                        begin
                            if (dr_ok)
                            begin
                                state_next = S_ISSUE;
                            end
                        end
                        mroe_pkg::CMD_DIV:
                        begin
                            if (dr_ok)
                            begin
                                if (in_op == '0)
                                begin
                                    stat_next = mroe_pkg::ST_DIVZ;
                                end else
                                begin
                                    state_next = S_ISSUE;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                d_next = rdata_a;
                s_next = rdata_b;
                case (cmd_reg)
                    mroe_pkg::CMD_READ:
                    begin
                        rd_next    = rdata_a;
                        state_next = S_DONE;
                    end
                    mroe_pkg::CMD_SWAP:
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = addr_a;
                        mem_wdata  = rdata_b;
                        state_next = S_SWP;
                    end
                    mroe_pkg::CMD_DIV:
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    default:
                    begin
                        state_next = S_MUL;
                    end
                endcase
            end
            S_MUL:
            begin
                if (cmd_reg == mroe_pkg::CMD_MUL)
                begin
                    prod_next = $signed(d_reg) * $signed(op_reg);
                end else
                begin
                    prod_next = $signed(s_reg) * $signed(op_reg);
                end
                state_next = S_SUM;
            end
            S_SUM:
            begin
                case (cmd_reg)
                    mroe_pkg::CMD_ADD:
                        wide_next = ($signed(66'($signed(d_reg))) <<< 16) + 66'(prod_reg);
                    mroe_pkg::CMD_SUB:
                        wide_next = ($signed(66'($signed(d_reg))) <<< 16) - 66'(prod_reg);
                    default:
                        wide_next = 66'(prod_reg);
                endcase
                state_next = S_RND;
            end
            S_RND:
            begin
                satv      = mroe_pkg::sat_q(wide_reg[65], rmag);
                mem_we    = 1'b1;
                mem_waddr = addr_a;
                mem_wdata = satv[DW-1:0];
                sat_next  = sat_reg || satv[DW];
                i_next    = i_reg + 1'b1;
                state_next = last_col ? S_DONE : S_ISSUE;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    satv      = mroe_pkg::sat_q(d_reg[DW-1] ^ op_reg[DW-1], {1'b0, div_quo});
                    mem_we    = 1'b1;
                    mem_waddr = addr_a;
                    mem_wdata = satv[DW-1:0];
                    sat_next  = sat_reg || satv[DW];
                    i_next    = i_reg + 1'b1;
                    state_next = last_col ? S_DONE : S_ISSUE;
                end
            end
            S_SWP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = addr_b;
                mem_wdata  = d_reg;
                i_next     = i_reg + 1'b1;
                state_next = last_col ? S_DONE : S_ISSUE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = rd_reg;
                    ouser_next  = sat_reg ? mroe_pkg::ST_SAT : stat_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            i_reg      <= '0;
        end else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            i_reg      <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        dr_reg    <= dr_next;
        sr_reg    <= sr_next;
        col_reg   <= col_next;
        op_reg    <= op_next;
        d_reg     <= d_next;
        s_reg     <= s_next;
        prod_reg  <= prod_next;
        wide_reg  <= wide_next;
        sat_reg   <= sat_next;
        stat_reg  <= stat_next;
        rd_reg    <= rd_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

    a_issue_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ISSUE |=> state_reg == S_LOAD)
        else $error("read issue not followed by load");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_stat.busy)
        else $error("divider did not start");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !(m_axis_tvalid && !m_axis_tready)) |=> m_axis_tvalid)
        else $error("finished command produced no result");

endmodule

>>> src/mroe_mem.sv
// Matrix storage: one write port, two registered read ports.
// Depends on mroe_pkg for the data width.
module mroe_mem #(
    parameter int DEPTH = mroe_pkg::ROWS_DEF * mroe_pkg::COLS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [mroe_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]               raddr_a,
    input  logic [AW-1:0]               raddr_b,
    output logic [mroe_pkg::DATA_W-1:0] rdata_a,
    output logic [mroe_pkg::DATA_W-1:0] rdata_b
);

    logic [mroe_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> src/mroe_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on mroe_pkg for widths and the status struct.
module mroe_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mroe_pkg::DIV_NW-1:0] num,
    input  logic [mroe_pkg::DIV_DW-1:0] den,
    output mroe_pkg::div_stat_t         stat,
    output logic [mroe_pkg::DIV_NW-1:0] quo
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [mroe_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic [mroe_pkg::DIV_RW-1:0] rem_reg, rem_next;
    logic [mroe_pkg::DIV_NW-1:0] num_reg, num_next;
    logic [mroe_pkg::DIV_DW-1:0] den_reg, den_next;
    logic [mroe_pkg::DIV_RW-1:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        trial     = {rem_reg[mroe_pkg::DIV_RW-2:0], num_reg[mroe_pkg::DIV_NW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = num;
            den_next  = den;
        end else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                num_next = {num_reg[mroe_pkg::DIV_NW-2:0], 1'b1};
            end else
            begin
                rem_next = trial;
                num_next = {num_reg[mroe_pkg::DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mroe_pkg::DIV_CW'(mroe_pkg::DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = num_reg;

endmodule
